// ===== src/avvs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// avvs_pkg: shared types and constants for the articulated vehicle velocity step
// Register indexes, word codes, sequencer states, fixed-point constants and the
// small helper functions used by the serial datapath.
// ----------------------------------------------------------------------------
package avvs_pkg;

    // Configuration register indexes.
    localparam int CFG_ADDR_W = 2;
    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_LAG_TC      = 2'd0,
        REG_DEAD_TIME   = 2'd1,
        REG_TRAILER_LEN = 2'd2,
        REG_HITCH_OFS   = 2'd3
    } cfg_reg_t;

    // Kind of input word, carried on tuser.
    localparam logic CMD_LATCH = 1'b0;
    localparam logic CMD_STEP  = 1'b1;

    // Sequencer states, one-hot.
    typedef enum logic [19:0] {
        ST_IDLE  = 20'h00001,
        ST_LAG   = 20'h00002,
        ST_DIV_N = 20'h00004,
        ST_DIV_R = 20'h00008,
        ST_T_MUL = 20'h00010,
        ST_T_DIV = 20'h00020,
        ST_EXP   = 20'h00040,
        ST_EXP_W = 20'h00080,
        ST_GAIN  = 20'h00100,
        ST_BL_S  = 20'h00200,
        ST_BL_R  = 20'h00400,
        ST_CS_H  = 20'h00800,
        ST_CS_A  = 20'h01000,
        ST_VX    = 20'h02000,
        ST_VY    = 20'h04000,
        ST_T1M   = 20'h08000,
        ST_T1D   = 20'h10000,
        ST_QM    = 20'h20000,
        ST_QD    = 20'h40000,
        ST_T2    = 20'h80000
    } state_t;

    // Fixed-point constants.
    localparam logic [32:0] Q32_ONE         = 33'h1_0000_0000;
    localparam logic [31:0] EXP_M1_Q32      = 32'd1580030169;
    localparam logic [33:0] CORDIC_GAIN_Q30 = 34'd652032874;
    localparam logic [32:0] Q_CLAMP         = 33'h1_FFFF_FFFF;
    localparam logic [3:0]  TAYLOR_TERMS    = 4'd12;

    // Arctangent of 2^-i as a 32-bit binary angle.
    function automatic logic [29:0] atan_q32(input logic [4:0] i);
        logic [29:0] a;
        unique case (i)
            5'd0:  a = 30'd536870912;
            5'd1:  a = 30'd316933406;
            5'd2:  a = 30'd167458907;
            5'd3:  a = 30'd85004756;
            5'd4:  a = 30'd42667331;
            5'd5:  a = 30'd21354465;
            5'd6:  a = 30'd10679838;
            5'd7:  a = 30'd5340245;
            5'd8:  a = 30'd2670163;
            5'd9:  a = 30'd1335087;
            5'd10: a = 30'd667544;
            5'd11: a = 30'd333772;
            5'd12: a = 30'd166886;
            5'd13: a = 30'd83443;
            5'd14: a = 30'd41722;
            5'd15: a = 30'd20861;
            5'd16: a = 30'd10430;
            5'd17: a = 30'd5215;
            5'd18: a = 30'd2608;
            5'd19: a = 30'd1304;
            5'd20: a = 30'd652;
            5'd21: a = 30'd326;
            5'd22: a = 30'd163;
            5'd23: a = 30'd81;
            default: a = '0;
        endcase
        return a;
    endfunction

    // Arithmetic right shift that rounds toward zero.
    function automatic logic signed [33:0] shr_tz(input logic signed [33:0] v,
                                                   input logic [4:0] sh);
        logic signed [33:0] bias;
        bias = v[33] ? ((34'sd1 <<< sh) - 34'sd1) : 34'sd0;
        return (v + bias) >>> sh;
    endfunction

    // Magnitude of a signed 32-bit value.
    function automatic logic [31:0] abs32(input logic signed [31:0] v);
        return v[31] ? (~v + 32'd1) : v;
    endfunction

    // Attach a sign to a magnitude.
    function automatic logic signed [65:0] apply_sign(input logic neg,
                                                       input logic [63:0] mag);
        logic signed [65:0] m;
        m = $signed({2'b00, mag});
        return neg ? -m : m;
    endfunction

    // Saturate to signed 32 bits.
    function automatic logic [31:0] sat32(input logic signed [65:0] v);
        logic [31:0] r;
        if (v > 66'sd2147483647) begin
            r = 32'h7FFF_FFFF;
        end else if (v < -66'sd2147483648) begin
            r = 32'h8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    // Clamp a CORDIC result to [-1, 1] in Q30.
    function automatic logic signed [31:0] clamp_q30(input logic signed [33:0] v);
        logic signed [31:0] r;
        if (v > 34'sd1073741824) begin
            r = 32'sd1073741824;
        end else if (v < -34'sd1073741824) begin
            r = -32'sd1073741824;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    // Move from start toward target by a step of the given magnitude.
    function automatic logic signed [31:0] blend(input logic signed [31:0] start,
                                                  input logic neg,
                                                  input logic [32:0] step);
        logic signed [33:0] s;
        s = neg ? ({{2{start[31]}}, start} - $signed({1'b0, step}))
                : ({{2{start[31]}}, start} + $signed({1'b0, step}));
        return s[31:0];
    endfunction

endpackage

// ===== src/articulated_vehicle_velocity_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// articulated_vehicle_velocity_step: tractor-trailer velocity model
// Lagged speed command tracking plus tractor and hitch velocity outputs,
// computed by a sequencer over a bit-serial divider, a 4-bit digit-serial
// multiplier and an iterative CORDIC rotator.
// ----------------------------------------------------------------------------
// A word with tuser 0 latches a new speed command and gives no result. A word
// with tuser 1 runs one control step and gives one result word. The block
// works on one word at a time. The bit-serial divider runs two divisions for
// the outputs and, while the lag is active, one for the whole time constants
// gone by and, when they are below 32, one more plus one per series term for
// the lag factor. A finished result waits in the output register while the
// next word is taken in.
module articulated_vehicle_velocity_step #(
    parameter int FRAC_BITS    = 16,
    parameter int ANGLE_BITS   = 16,
    parameter int CORDIC_STEPS = 16
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    // Input words.
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // time_now[31:0], target_linear_speed[63:32], target_turn_rate[95:64],
    // heading[111:96], hitch_angle[127:112]
    input  logic [127:0]                s_tdata,
    // command[0]
    input  logic [0:0]                  s_tuser,
    // Result words.
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // velocity_x[31:0], velocity_y[63:32], turn_rate[95:64], hitch_rate[127:96]
    output logic [127:0]                m_tdata,
    // Configuration writes.
    input  logic                        cfg_we,
    input  avvs_pkg::cfg_reg_t          cfg_addr,
    input  logic [31:0]                 cfg_wdata
);
    import avvs_pkg::*;

    localparam int          DEN_W     = 61 - FRAC_BITS;
    localparam int          LEN_SHIFT = 30 - FRAC_BITS;
    localparam logic [31:0] ANG_MASK  = 32'((64'd1 << ANGLE_BITS) - 64'd1);
    localparam logic [4:0]  STEP_LAST = 5'(CORDIC_STEPS - 1);

    // Sequencer and handshake.
    state_t              state_reg, state_next;
    logic                m_tvalid_reg, m_tvalid_next;

    // Configuration registers.
    logic [15:0]         lag_tc_reg, dead_time_reg;
    logic [30:0]         trailer_len_reg;
    logic signed [31:0]  hitch_ofs_reg;

    // Model state.
    logic [31:0]         command_time_reg, command_time_next;
    logic signed [31:0]  target_speed_reg, target_speed_next;
    logic signed [31:0]  target_rate_reg, target_rate_next;
    logic signed [31:0]  start_speed_reg, start_speed_next;
    logic signed [31:0]  start_rate_reg, start_rate_next;
    logic signed [31:0]  applied_speed_reg, applied_speed_next;
    logic signed [31:0]  applied_rate_reg, applied_rate_next;

    // Latched step word.
    logic [31:0]         time_now_reg, time_now_next;
    logic [15:0]         heading_reg, heading_next;
    logic [15:0]         hitch_angle_reg, hitch_angle_next;

    // Lag factor working registers.
    logic [4:0]          n_reg, n_next;
    logic [31:0]         r_reg, r_next;
    logic signed [34:0]  sum_reg, sum_next;
    logic [3:0]          k_reg, k_next;
    logic [32:0]         val_reg, val_next;
    logic [30:0]         gain_reg, gain_next;

    // Trig values and partial results.
    logic signed [31:0]  sin_h_reg, sin_h_next, cos_h_reg, cos_h_next;
    logic signed [31:0]  sin_a_reg, sin_a_next, cos_a_reg, cos_a_next;
    logic [31:0]         vx_reg, vx_next, vy_reg, vy_next;
    logic                t1_neg_reg, t1_neg_next, q_neg_reg, q_neg_next;
    logic signed [65:0]  part_reg, part_next;

    // Output register.
    logic [31:0]         out_vx_reg, out_vx_next, out_vy_reg, out_vy_next;
    logic [31:0]         out_w_reg, out_w_next, out_hr_reg, out_hr_next;

    // Digit-serial multiplier.
    logic [32:0]         mul_a_reg, mul_a_next;
    logic [31:0]         mul_b_reg, mul_b_next;
    logic [64:0]         mul_acc_reg, mul_acc_next;
    logic [3:0]          mul_cnt_reg, mul_cnt_next;
    logic [36:0]         mul_pp;
    logic                mul_go;
    logic [32:0]         mul_a_in;
    logic [31:0]         mul_b_in;

    // Bit-serial divider.
    logic [63:0]         div_num_reg, div_num_next;
    logic [DEN_W-1:0]    div_rem_reg, div_rem_next, div_den_reg, div_den_next;
    logic [6:0]          div_cnt_reg, div_cnt_next;
    logic [DEN_W:0]      div_trial, div_diff;
    logic                div_ge, div_go;
    logic [63:0]         div_num_in;
    logic [DEN_W-1:0]    div_den_in;

    // CORDIC rotator.
    logic signed [33:0]  cor_x_reg, cor_x_next, cor_y_reg, cor_y_next;
    logic signed [33:0]  cor_z_reg, cor_z_next;
    logic [4:0]          cor_idx_reg, cor_idx_next;
    logic                cor_run_reg, cor_run_next, cor_flip_reg, cor_flip_next;
    logic signed [33:0]  cor_sx, cor_sy, cor_ang, cor_xf, cor_yf;
    logic signed [31:0]  cor_cos, cor_sin;
    logic                cor_go, cor_flip_in;
    logic [15:0]         cor_ang_in;
    logic [31:0]         cor_z32, cor_z32f;

    // Helper values for the sequencer.
    logic                unit_busy;
    logic [31:0]         raw_time, elapsed;
    logic [30:0]         len;
    logic signed [32:0]  d_speed, d_rate;
    logic [32:0]         d_speed_mag, d_rate_mag;
    logic [31:0]         v_mag, w_mag, h_mag;
    logic signed [34:0]  sum_calc;
    logic [32:0]         term_calc, val_calc, qmag_calc;
    logic [30:0]         gain_calc;
    logic [32:0]         gain_sub;
    logic signed [65:0]  t1_calc, t2_calc;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {out_hr_reg, out_w_reg, out_vy_reg, out_vx_reg};

    assign unit_busy = (mul_cnt_reg != 4'd0) || (div_cnt_reg != 7'd0) || cor_run_reg;

    // Multiplier datapath: one 4-bit digit of B per cycle, most significant first.
    assign mul_pp = mul_a_reg * mul_b_reg[31:28];

    // Divider datapath: one quotient bit per cycle, restoring.
    assign div_trial = {div_rem_reg, div_num_reg[63]};
    assign div_ge    = (div_trial >= {1'b0, div_den_reg});
    assign div_diff  = div_trial - {1'b0, div_den_reg};

    // CORDIC datapath: one rotation per cycle.
    assign cor_sx  = shr_tz(cor_x_reg, cor_idx_reg);
    assign cor_sy  = shr_tz(cor_y_reg, cor_idx_reg);
    assign cor_ang = $signed({4'b0000, atan_q32(cor_idx_reg)});
    assign cor_xf  = cor_flip_reg ? -cor_x_reg : cor_x_reg;
    assign cor_yf  = cor_flip_reg ? -cor_y_reg : cor_y_reg;
    assign cor_cos = clamp_q30(cor_xf);
    assign cor_sin = clamp_q30(cor_yf);

    // Angle setup: scale to a 32-bit binary angle, fold into the right half-plane.
    assign cor_z32     = (32'(cor_ang_in) & ANG_MASK) << (32 - ANGLE_BITS);
    assign cor_flip_in = cor_z32[31] ^ cor_z32[30];
    assign cor_z32f    = {cor_z32[31] ^ cor_flip_in, cor_z32[30:0]};

    // Elapsed time and blend operands.
    assign raw_time = (time_now_reg >= command_time_reg) ? (time_now_reg - command_time_reg)
                                                          : 32'd0;
    assign elapsed  = raw_time - 32'(dead_time_reg);
    assign len      = (trailer_len_reg == 31'd0) ? 31'd1 : trailer_len_reg;
    assign d_speed  = {target_speed_reg[31], target_speed_reg}
                    - {start_speed_reg[31], start_speed_reg};
    assign d_rate   = {target_rate_reg[31], target_rate_reg}
                    - {start_rate_reg[31], start_rate_reg};
    assign d_speed_mag = d_speed[32] ? (~d_speed + 33'd1) : d_speed;
    assign d_rate_mag  = d_rate[32] ? (~d_rate + 33'd1) : d_rate;
    assign v_mag    = abs32(applied_speed_reg);
    assign w_mag    = abs32(applied_rate_reg);
    assign h_mag    = abs32(hitch_ofs_reg);

    // Series term, running sum and clamp of the decay factor.
    assign term_calc = div_num_reg[32:0];
    assign sum_calc  = k_reg[0] ? (sum_reg - $signed({2'b00, term_calc}))
                                : (sum_reg + $signed({2'b00, term_calc}));
    assign val_calc  = sum_calc[34] ? 33'd0
                     : ((sum_calc > $signed({2'b00, Q32_ONE})) ? Q32_ONE : sum_calc[32:0]);
    assign gain_sub  = Q32_ONE - val_reg;
    assign gain_calc = gain_sub[32:2];
    assign qmag_calc = (div_num_reg > 64'(Q_CLAMP)) ? Q_CLAMP : div_num_reg[32:0];
    assign t1_calc   = apply_sign(t1_neg_reg, div_num_reg);
    assign t2_calc   = apply_sign(q_neg_reg ^ cos_a_reg[31], 64'(mul_acc_reg[64:30]));

    always_comb begin
        state_next         = state_reg;
        m_tvalid_next      = m_tvalid_reg;
        command_time_next  = command_time_reg;
        target_speed_next  = target_speed_reg;
        target_rate_next   = target_rate_reg;
        start_speed_next   = start_speed_reg;
        start_rate_next    = start_rate_reg;
        applied_speed_next = applied_speed_reg;
        applied_rate_next  = applied_rate_reg;
        time_now_next      = time_now_reg;
        heading_next       = heading_reg;
        hitch_angle_next   = hitch_angle_reg;
        n_next             = n_reg;
        r_next             = r_reg;
        sum_next           = sum_reg;
        k_next             = k_reg;
        val_next           = val_reg;
        gain_next          = gain_reg;
        sin_h_next         = sin_h_reg;
        cos_h_next         = cos_h_reg;
        sin_a_next         = sin_a_reg;
        cos_a_next         = cos_a_reg;
        vx_next            = vx_reg;
        vy_next            = vy_reg;
        t1_neg_next        = t1_neg_reg;
        q_neg_next         = q_neg_reg;
        part_next          = part_reg;
        out_vx_next        = out_vx_reg;
        out_vy_next        = out_vy_reg;
        out_w_next         = out_w_reg;
        out_hr_next        = out_hr_reg;
        mul_a_next         = mul_a_reg;
        mul_b_next         = mul_b_reg;
        mul_acc_next       = mul_acc_reg;
        mul_cnt_next       = mul_cnt_reg;
        div_num_next       = div_num_reg;
        div_rem_next       = div_rem_reg;
        div_den_next       = div_den_reg;
        div_cnt_next       = div_cnt_reg;
        cor_x_next         = cor_x_reg;
        cor_y_next         = cor_y_reg;
        cor_z_next         = cor_z_reg;
        cor_idx_next       = cor_idx_reg;
        cor_run_next       = cor_run_reg;
        cor_flip_next      = cor_flip_reg;
        mul_go             = 1'b0;
        mul_a_in           = '0;
        mul_b_in           = '0;
        div_go             = 1'b0;
        div_num_in         = '0;
        div_den_in         = '0;
        cor_go             = 1'b0;
        cor_ang_in         = '0;

        // Multiplier iteration.
        if (mul_cnt_reg != 4'd0) begin
            mul_acc_next = (mul_acc_reg << 4) + 65'(mul_pp);
            mul_b_next   = mul_b_reg << 4;
            mul_cnt_next = mul_cnt_reg - 4'd1;
        end

        // Divider iteration.
        if (div_cnt_reg != 7'd0) begin
            div_rem_next = div_ge ? div_diff[DEN_W-1:0] : div_trial[DEN_W-1:0];
            div_num_next = {div_num_reg[62:0], div_ge};
            div_cnt_next = div_cnt_reg - 7'd1;
        end

        // CORDIC iteration.
        if (cor_run_reg) begin
            if (!cor_z_reg[33]) begin
                cor_x_next = cor_x_reg - cor_sy;
                cor_y_next = cor_y_reg + cor_sx;
                cor_z_next = cor_z_reg - cor_ang;
            end else begin
                cor_x_next = cor_x_reg + cor_sy;
                cor_y_next = cor_y_reg - cor_sx;
                cor_z_next = cor_z_reg + cor_ang;
            end
            cor_idx_next = cor_idx_reg + 5'd1;
            if (cor_idx_reg == STEP_LAST) begin
                cor_run_next = 1'b0;
            end
        end

        // Result word leaves the output register.
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        // Sequencer.
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    if (s_tuser[0] == CMD_LATCH) begin
                        command_time_next = s_tdata[31:0];
                        target_speed_next = s_tdata[63:32];
                        target_rate_next  = s_tdata[95:64];
                        start_speed_next  = applied_speed_reg;
                        start_rate_next   = applied_rate_reg;
                    end else begin
                        time_now_next    = s_tdata[31:0];
                        heading_next     = s_tdata[111:96];
                        hitch_angle_next = s_tdata[127:112];
                        state_next       = ST_LAG;
                    end
                end
            end
            ST_LAG: begin
                priority if (lag_tc_reg == 16'd0 && dead_time_reg == 16'd0) begin
                    applied_speed_next = target_speed_reg;
                    applied_rate_next  = target_rate_reg;
                    cor_go             = 1'b1;
                    cor_ang_in         = heading_reg;
                    state_next         = ST_CS_H;
                end else if (raw_time <= 32'(dead_time_reg)) begin
                    applied_speed_next = start_speed_reg;
                    applied_rate_next  = start_rate_reg;
                    cor_go             = 1'b1;
                    cor_ang_in         = heading_reg;
                    state_next         = ST_CS_H;
                end else if (lag_tc_reg == 16'd0) begin
                    applied_speed_next = target_speed_reg;
                    applied_rate_next  = target_rate_reg;
                    cor_go             = 1'b1;
                    cor_ang_in         = heading_reg;
                    state_next         = ST_CS_H;
                end else begin
                    div_go     = 1'b1;
                    div_num_in = 64'(elapsed);
                    div_den_in = DEN_W'(lag_tc_reg);
                    state_next = ST_DIV_N;
                end
            end
            ST_DIV_N: begin
                if (!unit_busy) begin
                    if (|div_num_reg[63:5]) begin
                        // Thirty-two or more time constants: the decay is zero.
                        val_next   = 33'd0;
                        state_next = ST_GAIN;
                    end else begin
                        n_next     = div_num_reg[4:0];
                        div_go     = 1'b1;
                        div_num_in = {16'd0, div_rem_reg[15:0], 32'd0};
                        div_den_in = DEN_W'(lag_tc_reg);
                        state_next = ST_DIV_R;
                    end
                end
            end
            ST_DIV_R: begin
                if (!unit_busy) begin
                    r_next     = div_num_reg[31:0];
                    sum_next   = $signed({2'b00, Q32_ONE});
                    k_next     = 4'd1;
                    mul_go     = 1'b1;
                    mul_a_in   = Q32_ONE;
                    mul_b_in   = div_num_reg[31:0];
                    state_next = ST_T_MUL;
                end
            end
            ST_T_MUL: begin
                if (!unit_busy) begin
                    div_go     = 1'b1;
                    div_num_in = 64'(mul_acc_reg[63:32]);
                    div_den_in = DEN_W'(k_reg);
                    state_next = ST_T_DIV;
                end
            end
            ST_T_DIV: begin
                if (!unit_busy) begin
                    sum_next = sum_calc;
                    if (k_reg == TAYLOR_TERMS) begin
                        val_next   = val_calc;
                        state_next = ST_EXP;
                    end else begin
                        k_next     = k_reg + 4'd1;
                        mul_go     = 1'b1;
                        mul_a_in   = term_calc;
                        mul_b_in   = r_reg;
                        state_next = ST_T_MUL;
                    end
                end
            end
            ST_EXP: begin
                if (n_reg == 5'd0) begin
                    state_next = ST_GAIN;
                end else begin
                    n_next     = n_reg - 5'd1;
                    mul_go     = 1'b1;
                    mul_a_in   = val_reg;
                    mul_b_in   = EXP_M1_Q32;
                    state_next = ST_EXP_W;
                end
            end
            ST_EXP_W: begin
                if (!unit_busy) begin
                    val_next   = {1'b0, mul_acc_reg[63:32]};
                    state_next = ST_EXP;
                end
            end
            ST_GAIN: begin
                gain_next  = gain_calc;
                mul_go     = 1'b1;
                mul_a_in   = d_speed_mag;
                mul_b_in   = 32'(gain_calc);
                state_next = ST_BL_S;
            end
            ST_BL_S: begin
                if (!unit_busy) begin
                    applied_speed_next = blend(start_speed_reg, d_speed[32],
                                               mul_acc_reg[62:30]);
                    mul_go     = 1'b1;
                    mul_a_in   = d_rate_mag;
                    mul_b_in   = 32'(gain_reg);
                    state_next = ST_BL_R;
                end
            end
            ST_BL_R: begin
                if (!unit_busy) begin
                    applied_rate_next = blend(start_rate_reg, d_rate[32], mul_acc_reg[62:30]);
                    cor_go     = 1'b1;
                    cor_ang_in = heading_reg;
                    state_next = ST_CS_H;
                end
            end
            ST_CS_H: begin
                if (!unit_busy) begin
                    sin_h_next = cor_sin;
                    cos_h_next = cor_cos;
                    cor_go     = 1'b1;
                    cor_ang_in = hitch_angle_reg;
                    state_next = ST_CS_A;
                end
            end
            ST_CS_A: begin
                if (!unit_busy) begin
                    sin_a_next = cor_sin;
                    cos_a_next = cor_cos;
                    mul_go     = 1'b1;
                    mul_a_in   = 33'(v_mag);
                    mul_b_in   = abs32(cos_h_reg);
                    state_next = ST_VX;
                end
            end
            ST_VX: begin
                if (!unit_busy) begin
                    vx_next  = sat32(apply_sign(applied_speed_reg[31] ^ cos_h_reg[31],
                                                64'(mul_acc_reg[64:30])));
                    mul_go     = 1'b1;
                    mul_a_in   = 33'(v_mag);
                    mul_b_in   = abs32(sin_h_reg);
                    state_next = ST_VY;
                end
            end
            ST_VY: begin
                if (!unit_busy) begin
                    vy_next  = sat32(apply_sign(applied_speed_reg[31] ^ sin_h_reg[31],
                                                64'(mul_acc_reg[64:30])));
                    mul_go     = 1'b1;
                    mul_a_in   = 33'(v_mag);
                    mul_b_in   = abs32(sin_a_reg);
                    state_next = ST_T1M;
                end
            end
            ST_T1M: begin
                if (!unit_busy) begin
                    t1_neg_next = applied_speed_reg[31] ^ sin_a_reg[31];
                    div_go      = 1'b1;
                    div_num_in  = mul_acc_reg[63:0];
                    div_den_in  = DEN_W'(len) << LEN_SHIFT;
                    state_next  = ST_T1D;
                end
            end
            ST_T1D: begin
                if (!unit_busy) begin
                    // Start the hitch-rate sum with the trailer and turn terms.
                    part_next  = -t1_calc - 66'(applied_rate_reg);
                    mul_go     = 1'b1;
                    mul_a_in   = 33'(h_mag);
                    mul_b_in   = w_mag;
                    state_next = ST_QM;
                end
            end
            ST_QM: begin
                if (!unit_busy) begin
                    q_neg_next = hitch_ofs_reg[31] ^ applied_rate_reg[31];
                    div_go     = 1'b1;
                    div_num_in = mul_acc_reg[63:0];
                    div_den_in = DEN_W'(len);
                    state_next = ST_QD;
                end
            end
            ST_QD: begin
                if (!unit_busy) begin
                    mul_go     = 1'b1;
                    mul_a_in   = qmag_calc;
                    mul_b_in   = abs32(cos_a_reg);
                    state_next = ST_T2;
                end
            end
            ST_T2: begin
                if (!unit_busy && (!m_tvalid_reg || m_tready)) begin
                    out_vx_next   = vx_reg;
                    out_vy_next   = vy_reg;
                    out_w_next    = applied_rate_reg;
                    out_hr_next   = sat32(part_reg - t2_calc);
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // Unit launches.
        if (mul_go) begin
            mul_a_next   = mul_a_in;
            mul_b_next   = mul_b_in;
            mul_acc_next = '0;
            mul_cnt_next = 4'd8;
        end
        if (div_go) begin
            div_num_next = div_num_in;
            div_den_next = div_den_in;
            div_rem_next = '0;
            div_cnt_next = 7'd64;
        end
        if (cor_go) begin
            cor_x_next    = CORDIC_GAIN_Q30;
            cor_y_next    = '0;
            cor_z_next    = {{2{cor_z32f[31]}}, cor_z32f};
            cor_idx_next  = '0;
            cor_flip_next = cor_flip_in;
            cor_run_next  = 1'b1;
        end
    end

    // Control, configuration and model state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= ST_IDLE;
            m_tvalid_reg      <= 1'b0;
            mul_cnt_reg       <= '0;
            div_cnt_reg       <= '0;
            cor_run_reg       <= 1'b0;
            lag_tc_reg        <= '0;
            dead_time_reg     <= '0;
            trailer_len_reg   <= 31'd327680;
            hitch_ofs_reg     <= '0;
            command_time_reg  <= '0;
            target_speed_reg  <= '0;
            target_rate_reg   <= '0;
            start_speed_reg   <= '0;
            start_rate_reg    <= '0;
            applied_speed_reg <= '0;
            applied_rate_reg  <= '0;
        end else begin
            state_reg         <= state_next;
            m_tvalid_reg      <= m_tvalid_next;
            mul_cnt_reg       <= mul_cnt_next;
            div_cnt_reg       <= div_cnt_next;
            cor_run_reg       <= cor_run_next;
            command_time_reg  <= command_time_next;
            target_speed_reg  <= target_speed_next;
            target_rate_reg   <= target_rate_next;
            start_speed_reg   <= start_speed_next;
            start_rate_reg    <= start_rate_next;
            applied_speed_reg <= applied_speed_next;
            applied_rate_reg  <= applied_rate_next;
            if (cfg_we) begin
                unique case (cfg_addr)
                    REG_LAG_TC:      lag_tc_reg      <= cfg_wdata[15:0];
                    REG_DEAD_TIME:   dead_time_reg   <= cfg_wdata[15:0];
                    REG_TRAILER_LEN: trailer_len_reg <= cfg_wdata[30:0];
                    REG_HITCH_OFS:   hitch_ofs_reg   <= cfg_wdata;
                    default:         lag_tc_reg      <= lag_tc_reg;
                endcase
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        time_now_reg    <= time_now_next;
        heading_reg     <= heading_next;
        hitch_angle_reg <= hitch_angle_next;
        n_reg           <= n_next;
        r_reg           <= r_next;
        sum_reg         <= sum_next;
        k_reg           <= k_next;
        val_reg         <= val_next;
        gain_reg        <= gain_next;
        sin_h_reg       <= sin_h_next;
        cos_h_reg       <= cos_h_next;
        sin_a_reg       <= sin_a_next;
        cos_a_reg       <= cos_a_next;
        vx_reg          <= vx_next;
        vy_reg          <= vy_next;
        t1_neg_reg      <= t1_neg_next;
        q_neg_reg       <= q_neg_next;
        part_reg        <= part_next;
        out_vx_reg      <= out_vx_next;
        out_vy_reg      <= out_vy_next;
        out_w_reg       <= out_w_next;
        out_hr_reg      <= out_hr_next;
        mul_a_reg       <= mul_a_next;
        mul_b_reg       <= mul_b_next;
        mul_acc_reg     <= mul_acc_next;
        div_num_reg     <= div_num_next;
        div_rem_reg     <= div_rem_next;
        div_den_reg     <= div_den_next;
        cor_x_reg       <= cor_x_next;
        cor_y_reg       <= cor_y_next;
        cor_z_reg       <= cor_z_next;
        cor_idx_reg     <= cor_idx_next;
        cor_flip_reg    <= cor_flip_next;
    end

endmodule
